// File: rtl/hrlp_pkg.sv
// shared types and constants for the http request line parser
package hrlp_pkg;

	localparam int unsigned METHOD_CAPACITY_DEF  = 16;
	localparam int unsigned PATH_CAPACITY_DEF    = 2048;
	localparam int unsigned VERSION_CAPACITY_DEF = 16;

	localparam logic [15:0] MIN_LINE = 16'd14;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_LO_Z  = 8'h7a;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_TILDE = 8'h7e;

	typedef enum logic [2:0] {
		PH_METHOD    = 3'd0,
		PH_PATH      = 3'd1,
		PH_VERSION   = 3'd2,
		PH_EXPECT_LF = 3'd3,
		PH_DONE      = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_RUNNING    = 3'd0,
		ST_COMPLETE   = 3'd1,
		ST_INCOMPLETE = 3'd2,
		ST_MALFORMED  = 3'd3,
		ST_TOO_LONG   = 3'd4,
		ST_IGNORED    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		FK_NONE    = 2'd0,
		FK_METHOD  = 2'd1,
		FK_PATH    = 2'd2,
		FK_VERSION = 2'd3
	} field_kind_t;

	typedef struct packed {
		phase_t      phase;
		logic [10:0] field_count;
		logic [15:0] byte_position;
		logic [15:0] latched_length;
	} parse_state_t;

	typedef struct packed {
		field_kind_t kind;
		logic [10:0] index;
		logic [7:0]  data;
		status_t     status;
		logic [15:0] line_length;
	} parse_result_t;

endpackage

// File: rtl/hrlp_step.sv
// next-state and result logic for one byte of the request line
module hrlp_step #(
	parameter int unsigned METHOD_CAPACITY  = hrlp_pkg::METHOD_CAPACITY_DEF,
	parameter int unsigned PATH_CAPACITY    = hrlp_pkg::PATH_CAPACITY_DEF,
	parameter int unsigned VERSION_CAPACITY = hrlp_pkg::VERSION_CAPACITY_DEF
) (
	input  hrlp_pkg::parse_state_t  cur,
	input  logic [7:0]              in_byte,
	input  logic                    first_of_buffer,
	input  logic [15:0]             buffer_length,
	output hrlp_pkg::parse_state_t  nxt,
	output hrlp_pkg::parse_result_t res
);

	localparam logic [11:0] M_CAP = 12'(METHOD_CAPACITY);
	localparam logic [11:0] P_CAP = 12'(PATH_CAPACITY);
	localparam logic [11:0] V_CAP = 12'(VERSION_CAPACITY);

	hrlp_pkg::parse_state_t st;
	hrlp_pkg::status_t      sts;
	logic [11:0]            cap;
	logic [11:0]            fc_inc;
	logic [16:0]            pos_inc;
	logic                   allowed;

	always_comb begin
		st = cur;
		if (first_of_buffer) begin
			st.phase          = hrlp_pkg::PH_METHOD;
			st.field_count    = '0;
			st.byte_position  = '0;
			st.latched_length = buffer_length;
		end

		unique case (st.phase)
			hrlp_pkg::PH_METHOD: begin
				cap     = M_CAP;
				allowed = (in_byte >= hrlp_pkg::CH_UP_A) && (in_byte <= hrlp_pkg::CH_LO_Z);
			end
			hrlp_pkg::PH_PATH: begin
				cap     = P_CAP;
				allowed = (in_byte >= hrlp_pkg::CH_BANG) && (in_byte <= hrlp_pkg::CH_TILDE);
			end
			default: begin
				cap     = V_CAP;
				allowed = (in_byte >= hrlp_pkg::CH_BANG) && (in_byte <= hrlp_pkg::CH_LO_Z);
			end
		endcase

		fc_inc  = {1'b0, st.field_count} + 12'd1;
		pos_inc = {1'b0, st.byte_position} + 17'd1;

		nxt             = st;
		sts             = hrlp_pkg::ST_RUNNING;
		res.kind        = hrlp_pkg::FK_NONE;
		res.index       = '0;
		res.data        = in_byte;
		res.line_length = '0;

		priority if (st.phase == hrlp_pkg::PH_DONE) begin
			sts = hrlp_pkg::ST_IGNORED;
		end else if (st.latched_length < hrlp_pkg::MIN_LINE) begin
			sts = hrlp_pkg::ST_INCOMPLETE;
		end else if (st.phase == hrlp_pkg::PH_EXPECT_LF) begin
			if (in_byte == hrlp_pkg::CH_LF) begin
				sts             = hrlp_pkg::ST_COMPLETE;
				res.line_length = pos_inc[15:0];
			end else begin
				sts = hrlp_pkg::ST_MALFORMED;
			end
		end else if (in_byte == hrlp_pkg::CH_SP) begin
			if (st.phase == hrlp_pkg::PH_VERSION || st.field_count == '0) begin
				sts = hrlp_pkg::ST_MALFORMED;
			end else begin
				nxt.phase       = (st.phase == hrlp_pkg::PH_METHOD) ? hrlp_pkg::PH_PATH
				                                                  : hrlp_pkg::PH_VERSION;
				nxt.field_count = '0;
			end
		end else if (st.phase == hrlp_pkg::PH_VERSION && in_byte == hrlp_pkg::CH_CR) begin
			if (st.field_count == '0) begin
				sts = hrlp_pkg::ST_MALFORMED;
			end else begin
				nxt.phase = hrlp_pkg::PH_EXPECT_LF;
			end
		end else if (!allowed) begin
			sts = hrlp_pkg::ST_MALFORMED;
		end else if (fc_inc >= cap) begin
			sts = hrlp_pkg::ST_TOO_LONG;
		end else begin
			unique case (st.phase)
				hrlp_pkg::PH_METHOD: res.kind = hrlp_pkg::FK_METHOD;
				hrlp_pkg::PH_PATH:   res.kind = hrlp_pkg::FK_PATH;
				default:             res.kind = hrlp_pkg::FK_VERSION;
			endcase
			res.index       = st.field_count;
			nxt.field_count = fc_inc[10:0];
		end

		if (sts == hrlp_pkg::ST_RUNNING && pos_inc >= {1'b0, st.latched_length}) begin
			sts = hrlp_pkg::ST_INCOMPLETE;
		end

		if (sts != hrlp_pkg::ST_RUNNING && sts != hrlp_pkg::ST_IGNORED) begin
			nxt.phase = hrlp_pkg::PH_DONE;
		end
		if (sts != hrlp_pkg::ST_IGNORED) begin
			nxt.byte_position = pos_inc[15:0];
		end

		res.status = sts;
	end

endmodule

// File: rtl/http_request_line_parser_core.sv
// top level of the http request line parser: input register, parse logic, result register
// Parses METHOD SP PATH SP VERSION CRLF one byte per item and returns one result per byte,
// with the byte's field, its index in that field and the parse status. Raise first_of_buffer
// on the first byte of each buffer; buffer_length is sampled with it. Throughput is one item
// per clock while result_ready is high; a stalled result holds the input register. Each item
// waits in the input register and moves into the result register once that register is free
// or being read, with the parse state updated at that edge. After a final status, bytes are
// reported as ignored until the next buffer.
module http_request_line_parser_core #(
	parameter int unsigned METHOD_CAPACITY  = hrlp_pkg::METHOD_CAPACITY_DEF,
	parameter int unsigned PATH_CAPACITY    = hrlp_pkg::PATH_CAPACITY_DEF,
	parameter int unsigned VERSION_CAPACITY = hrlp_pkg::VERSION_CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  in_byte,
	input  logic        first_of_buffer,
	input  logic [15:0] buffer_length,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  field_kind,
	output logic [10:0] field_index,
	output logic [7:0]  out_byte,
	output logic [2:0]  status,
	output logic [15:0] line_length
);

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    first_s1;
	logic [15:0]             length_s1;
	logic                    valid_s2;
	hrlp_pkg::parse_result_t res_s2;
	hrlp_pkg::parse_state_t  state_q;
	hrlp_pkg::parse_state_t  state_nxt;
	hrlp_pkg::parse_result_t res_nxt;
	logic                    advance;

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	hrlp_step #(
		.METHOD_CAPACITY  (METHOD_CAPACITY),
		.PATH_CAPACITY    (PATH_CAPACITY),
		.VERSION_CAPACITY (VERSION_CAPACITY)
	) u_step (
		.cur             (state_q),
		.in_byte         (byte_s1),
		.first_of_buffer (first_s1),
		.buffer_length   (length_s1),
		.nxt             (state_nxt),
		.res             (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1               <= 1'b0;
			valid_s2               <= 1'b0;
			state_q.phase          <= hrlp_pkg::PH_METHOD;
			state_q.field_count    <= '0;
			state_q.byte_position  <= '0;
			state_q.latched_length <= '0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			byte_s1   <= in_byte;
			first_s1  <= first_of_buffer;
			length_s1 <= buffer_length;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign field_kind   = res_s2.kind;
	assign field_index  = res_s2.index;
	assign out_byte     = res_s2.data;
	assign status       = res_s2.status;
	assign line_length  = res_s2.line_length;

endmodule
